FILE: rtl/ctw_pkg.sv
// Shared types, codes and character constants for the C source word tokenizer.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package ctw_pkg;

    // Tokenizer modes
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_SLASH = 3'd1;
    localparam logic [2:0] M_LINE  = 3'd2;
    localparam logic [2:0] M_BLOCK = 3'd3;
    localparam logic [2:0] M_BSTAR = 3'd4;
    localparam logic [2:0] M_PREP  = 3'd5;
    localparam logic [2:0] M_IDENT = 3'd6;
    localparam logic [2:0] M_STR   = 3'd7;

    // Token kinds
    localparam logic [1:0] K_IDENT = 2'd0;
    localparam logic [1:0] K_STR   = 2'd1;
    localparam logic [1:0] K_OTHER = 2'd2;
    localparam logic [1:0] K_END   = 2'd3;

    // Characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam logic [7:0] MAX_TOKEN_LEN_RESET = 8'd99;

    // Result slots for one input item; one step produces at most two results
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } ctw_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic [1:0] kind;
        logic       last;
    } ctw_out_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       at_line_start;
        logic [7:0] quote_delim;
        logic [7:0] held_char;
        logic       held_valid;
        logic [7:0] token_len;
    } ctw_state_t;

    // Results of one step, handed to the result buffer
    typedef struct packed {
        logic [1:0]                       count;
        ctw_out_t [MAX_RESULTS-1:0]       items;
    } ctw_load_t;

    localparam ctw_state_t STATE_RESET = '{
        mode:          M_IDLE,
        at_line_start: 1'b1,
        quote_delim:   8'h00,
        held_char:     8'h00,
        held_valid:    1'b0,
        token_len:     8'h00
    };

    function automatic ctw_out_t make_res(logic [7:0] c, logic has, logic [1:0] kind,
                                          logic last);
        ctw_out_t r;
        r.out_char = c;
        r.has_char = has;
        r.kind     = kind;
        r.last     = last;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ctw_step.sv
// One tokenizer step: next state and up to two results for one input item.
// Depends on ctw_pkg.
`default_nettype none

module ctw_step
    import ctw_pkg::*;
(
    input  wire ctw_state_t st,
    input  wire ctw_in_t    item,
    input  wire [7:0]       max_token_len,
    output ctw_state_t      st_next,
    output ctw_load_t       load
);

    always_comb
    begin
        ctw_state_t s;
        ctw_out_t   res [MAX_RESULTS];
        logic [1:0] n;
        logic [7:0] c;
        logic       run_idle;
        logic       do_add;
        logic [1:0] add_kind;
        logic       is_space;
        logic       is_alpha;
        logic       is_word;

        s        = st;
        n        = 2'd0;
        c        = item.ch;
        run_idle = 1'b0;
        do_add   = 1'b0;
        add_kind = K_IDENT;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        is_space = (c inside {[8'h09:8'h0D], 8'h20});
        is_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
        is_word  = is_alpha || (c inside {[8'h30:8'h39]}) || (c == CH_UNDER);

        if (item.end_of_input)
        begin
            // flush whatever token is open, then the end marker
            if (s.mode == M_IDENT && s.held_valid)
            begin
                res[n] = make_res(s.held_char, 1'b1, K_IDENT, 1'b1);
                n = n + 2'd1;
            end
            else if (s.mode == M_STR)
            begin
                if (s.held_valid)
                    res[n] = make_res(s.held_char, 1'b1, K_STR, 1'b1);
                else
                    res[n] = make_res(8'h00, 1'b0, K_STR, 1'b1);
                n = n + 2'd1;
            end
            else if (s.mode == M_SLASH)
            begin
                res[n] = make_res(CH_SLASH, 1'b1, K_OTHER, 1'b1);
                n = n + 2'd1;
            end
            res[n] = make_res(8'h00, 1'b0, K_END, 1'b1);
            n = n + 2'd1;
            s = STATE_RESET;
        end
        else
        begin
            case (s.mode)
                M_SLASH:
                begin
                    if (c == CH_SLASH)
                        s.mode = M_LINE;
                    else if (c == CH_STAR)
                        s.mode = M_BLOCK;
                    else
                    begin
                        res[n] = make_res(CH_SLASH, 1'b1, K_OTHER, 1'b1);
                        n = n + 2'd1;
                        s.mode = M_IDLE;
                        run_idle = 1'b1;
                    end
                end
                M_LINE, M_PREP:
                begin
                    if (c == CH_NL)
                    begin
                        s.mode = M_IDLE;
                        s.at_line_start = 1'b1;
                    end
                end
                M_BLOCK:
                begin
                    if (c == CH_STAR)
                        s.mode = M_BSTAR;
                    else if (c == CH_NL)
                        s.at_line_start = 1'b1;
                end
                M_BSTAR:
                begin
                    if (c == CH_SLASH)
                        s.mode = M_IDLE;
                    else if (c != CH_STAR)
                    begin
                        s.mode = M_BLOCK;
                        if (c == CH_NL)
                            s.at_line_start = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_word)
                    begin
                        do_add   = 1'b1;
                        add_kind = K_IDENT;
                    end
                    else
                    begin
                        if (s.held_valid)
                        begin
                            res[n] = make_res(s.held_char, 1'b1, K_IDENT, 1'b1);
                            n = n + 2'd1;
                        end
                        s.held_valid = 1'b0;
                        s.held_char  = 8'h00;
                        s.token_len  = 8'h00;
                        s.mode       = M_IDLE;
                        run_idle     = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (c == s.quote_delim)
                    begin
                        if (s.held_valid && s.held_char == CH_BSLASH)
                            s.held_char = c;   // escaped delimiter
                        else
                        begin
                            if (s.held_valid)
                                res[n] = make_res(s.held_char, 1'b1, K_STR, 1'b1);
                            else
                                res[n] = make_res(8'h00, 1'b0, K_STR, 1'b1);
                            n = n + 2'd1;
                            s.held_valid = 1'b0;
                            s.held_char  = 8'h00;
                            s.token_len  = 8'h00;
                            s.mode       = M_IDLE;
                        end
                    end
                    else
                    begin
                        do_add   = 1'b1;
                        add_kind = K_STR;
                    end
                end
                default:
                begin
                    s.mode   = M_IDLE;
                    run_idle = 1'b1;
                end
            endcase

            // Classify a byte seen between tokens
            if (run_idle)
            begin
                if (is_space)
                begin
                    if (c == CH_NL)
                        s.at_line_start = 1'b1;
                end
                else if (c == CH_HASH && s.at_line_start)
                    s.mode = M_PREP;
                else
                begin
                    s.at_line_start = 1'b0;
                    if (c == CH_SLASH)
                        s.mode = M_SLASH;
                    else if (c == CH_SQUOTE || c == CH_DQUOTE)
                    begin
                        s.mode        = M_STR;
                        s.quote_delim = c;
                        s.held_valid  = 1'b0;
                        s.token_len   = 8'h00;
                    end
                    else if (is_alpha || c == CH_UNDER)
                    begin
                        s.mode       = M_IDENT;
                        s.held_valid = 1'b0;
                        s.token_len  = 8'h00;
                        do_add       = 1'b1;
                        add_kind     = K_IDENT;
                    end
                    else
                    begin
                        res[n] = make_res(c, 1'b1, K_OTHER, 1'b1);
                        n = n + 2'd1;
                    end
                end
            end

            // Append to the open token; cut it at the length limit
            if (do_add)
            begin
                if (s.held_valid)
                begin
                    res[n] = make_res(s.held_char, 1'b1, add_kind, 1'b0);
                    n = n + 2'd1;
                end
                s.token_len = s.token_len + 8'd1;
                if (s.token_len >= max_token_len)
                begin
                    res[n] = make_res(c, 1'b1, add_kind, 1'b1);
                    n = n + 2'd1;
                    s.held_valid = 1'b0;
                    s.held_char  = 8'h00;
                    s.token_len  = 8'h00;
                    s.mode       = M_IDLE;
                end
                else
                begin
                    s.held_char  = c;
                    s.held_valid = 1'b1;
                end
            end
        end

        st_next    = s;
        load.count = n;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            load.items[i] = res[i];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ctw_outbuf.sv
// Result buffer: holds the up to two results of one step and drains them in order.
// Depends on ctw_pkg.
`default_nettype none

module ctw_outbuf
    import ctw_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            load_en,
    input  wire ctw_load_t load,
    input  wire            pop,
    output logic [1:0]     count,
    output ctw_out_t       head
);

    logic [1:0]                 count_reg;
    logic [1:0]                 count_next;
    ctw_out_t [MAX_RESULTS-1:0] items_reg;
    ctw_out_t [MAX_RESULTS-1:0] items_next;

    always_comb
    begin
        count_next = count_reg;
        items_next = items_reg;
        if (load_en)
        begin
            // load only happens when the buffer is empty or empties this cycle
            count_next = load.count;
            items_next = load.items;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                items_next[i] = items_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

    assign count = count_reg;
    assign head  = items_reg[0];

endmodule

`default_nettype wire

FILE: rtl/c_source_word_tokenizer.sv
// Top level of the C source word tokenizer: input register, step logic, result buffer.
// Depends on ctw_pkg, ctw_step and ctw_outbuf.
`default_nettype none

// The tokenizer takes one C source byte per transaction and returns token characters
// as result transactions, one per character, with last set on the final character of
// each token and an end marker after an end_of_input transaction. Each byte is held in
// the input register and processed by the step logic, which writes its zero to two
// results into a three-entry result buffer. A new byte is taken every cycle as long as
// every byte yields at most one result and the output is not stalled; otherwise
// throughput is set by the result buffer, which drains one transaction per cycle while
// the output is not stalled. Whitespace and comment bytes yield no result and pass at
// one per cycle while the buffer is empty. max_token_len is written through the
// cfg port (always ready) and must only change while no transaction is in flight.
module c_source_word_tokenizer
    import ctw_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    // byte input
    input  wire          in_valid,
    output logic         in_stall,
    input  wire ctw_in_t in_item,
    // token output
    output logic         out_valid,
    input  wire          out_stall,
    output ctw_out_t     out_item,
    // max_token_len write
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [7:0]    cfg_data
);

    logic [7:0] max_token_len_reg;

    logic       in_full_reg;
    ctw_in_t    in_data_reg;

    ctw_state_t state_reg;
    ctw_state_t state_next;
    ctw_load_t  load;

    logic [1:0] buf_count;
    logic       pop;
    logic       fire;
    logic       in_take;

    assign cfg_ready = 1'b1;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_token_len_reg <= MAX_TOKEN_LEN_RESET;
        else if (cfg_valid && cfg_ready)
            max_token_len_reg <= cfg_data;
    end

    // Process the held byte when the buffer is empty or drains its last entry now
    assign pop      = out_valid && !out_stall;
    assign fire     = in_full_reg && (buf_count == 2'd0 || (buf_count == 2'd1 && pop));
    assign in_stall = in_full_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // Input register: hold the byte until the step logic takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_take)
            in_full_reg <= 1'b1;
        else if (fire)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_item;
    end

    ctw_step u_step (
        .st            (state_reg),
        .item          (in_data_reg),
        .max_token_len (max_token_len_reg),
        .st_next       (state_next),
        .load          (load)
    );

    // Tokenizer state: advance once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (fire)
            state_reg <= state_next;
    end

    ctw_outbuf u_outbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load_en (fire),
        .load    (load),
        .pop     (pop),
        .count   (buf_count),
        .head    (out_item)
    );

    assign out_valid = (buf_count != 2'd0);

    // A processed byte leaves exactly its results in the buffer
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> buf_count == $past(load.count))
        else $error("result buffer count does not match step results");

    // Only an open identifier or literal holds a character
    a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.held_valid |-> (state_reg.mode == M_IDENT || state_reg.mode == M_STR))
        else $error("held character outside an identifier or literal");

    // Single-character tokens and end markers always close
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind == K_OTHER || out_item.kind == K_END) |-> out_item.last)
        else $error("single-character token without last");

    // Stall only while a byte is waiting in the input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg && !fire)
        else $error("input stalled with no byte waiting");

endmodule

`default_nettype wire

FILE: tb/c_source_word_tokenizer_tb.sv
// Self-checking testbench for c_source_word_tokenizer: a directed byte stream, then random
// C-like fragments under several max_token_len settings, checked against a local predictor.
// Depends on ctw_pkg and the rtl top level only.
`timescale 1ns / 1ps

module c_source_word_tokenizer_tb;
    import ctw_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    ctw_in_t    in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    ctw_out_t   out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;

    c_source_word_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Source bytes waiting for the driver, and token characters waiting for the output.
    ctw_in_t  byte_q[$];
    ctw_out_t token_q[$];
    int       err_count = 0;

    // Local copy of the tokenizer state and of the max_token_len register.
    logic [2:0] tk_mode;
    logic       tk_line_start;
    logic [7:0] tk_delim;
    logic [7:0] tk_held;
    logic       tk_held_v;
    logic [7:0] tk_len;
    logic [7:0] tk_max;

    // Driver burst shaping and receiver stall pattern.
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned cyc = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == CH_NL || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9") || c == CH_UNDER;
    endfunction

    task automatic clear_tokenizer();
        tk_mode       = M_IDLE;
        tk_line_start = 1'b1;
        tk_delim      = 8'h00;
        tk_held       = 8'h00;
        tk_held_v     = 1'b0;
        tk_len        = 8'h00;
    endtask

    task automatic push_token_char(input logic [7:0] c, input logic has, input logic [1:0] kind,
                                   input logic last);
        ctw_out_t r;
        r.out_char = c;
        r.has_char = has;
        r.kind     = kind;
        r.last     = last;
        token_q.push_back(r);
    endtask

    // Add one character to the open multi-character token; cut it at the length limit.
    task automatic token_append(input logic [7:0] c, input logic [1:0] kind);
        if (tk_held_v)
            push_token_char(tk_held, 1'b1, kind, 1'b0);
        tk_len = tk_len + 8'd1;
        if (tk_len >= tk_max)
        begin
            push_token_char(c, 1'b1, kind, 1'b1);
            tk_held_v = 1'b0;
            tk_held   = 8'h00;
            tk_len    = 8'h00;
            tk_mode   = M_IDLE;
        end
        else
        begin
            tk_held   = c;
            tk_held_v = 1'b1;
        end
    endtask

    // Handle a byte seen between tokens.
    task automatic idle_byte(input logic [7:0] c);
        if (is_blank(c))
        begin
            if (c == CH_NL)
                tk_line_start = 1'b1;
        end
        else if (c == CH_HASH && tk_line_start)
            tk_mode = M_PREP;
        else
        begin
            tk_line_start = 1'b0;
            if (c == CH_SLASH)
                tk_mode = M_SLASH;
            else if (c == CH_SQUOTE || c == CH_DQUOTE)
            begin
                tk_mode   = M_STR;
                tk_delim  = c;
                tk_held_v = 1'b0;
                tk_len    = 8'h00;
            end
            else if (is_letter(c) || c == CH_UNDER)
            begin
                tk_mode   = M_IDENT;
                tk_held_v = 1'b0;
                tk_len    = 8'h00;
                token_append(c, K_IDENT);
            end
            else
                push_token_char(c, 1'b1, K_OTHER, 1'b1);
        end
    endtask

    // Advance the predictor by one accepted source transaction.
    task automatic tokenize_byte(input ctw_in_t it);
        logic [7:0] c;
        c = it.ch;
        if (it.end_of_input)
        begin
            // Flush whatever token is open, then emit the end marker.
            if (tk_mode == M_IDENT && tk_held_v)
                push_token_char(tk_held, 1'b1, K_IDENT, 1'b1);
            else if (tk_mode == M_STR)
            begin
                if (tk_held_v)
                    push_token_char(tk_held, 1'b1, K_STR, 1'b1);
                else
                    push_token_char(8'h00, 1'b0, K_STR, 1'b1);
            end
            else if (tk_mode == M_SLASH)
                push_token_char(CH_SLASH, 1'b1, K_OTHER, 1'b1);
            push_token_char(8'h00, 1'b0, K_END, 1'b1);
            clear_tokenizer();
        end
        else
        begin
            case (tk_mode)
                M_SLASH:
                begin
                    if (c == CH_SLASH)
                        tk_mode = M_LINE;
                    else if (c == CH_STAR)
                        tk_mode = M_BLOCK;
                    else
                    begin
                        // Lone slash: emit it and tokenize this byte as usual.
                        push_token_char(CH_SLASH, 1'b1, K_OTHER, 1'b1);
                        tk_mode = M_IDLE;
                        idle_byte(c);
                    end
                end
                M_LINE, M_PREP:
                begin
                    if (c == CH_NL)
                    begin
                        tk_mode       = M_IDLE;
                        tk_line_start = 1'b1;
                    end
                end
                M_BLOCK:
                begin
                    if (c == CH_STAR)
                        tk_mode = M_BSTAR;
                    else if (c == CH_NL)
                        tk_line_start = 1'b1;
                end
                M_BSTAR:
                begin
                    if (c == CH_SLASH)
                        tk_mode = M_IDLE;
                    else if (c != CH_STAR)
                    begin
                        tk_mode = M_BLOCK;
                        if (c == CH_NL)
                            tk_line_start = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_word_char(c))
                        token_append(c, K_IDENT);
                    else
                    begin
                        if (tk_held_v)
                            push_token_char(tk_held, 1'b1, K_IDENT, 1'b1);
                        tk_held_v = 1'b0;
                        tk_held   = 8'h00;
                        tk_len    = 8'h00;
                        tk_mode   = M_IDLE;
                        idle_byte(c);
                    end
                end
                M_STR:
                begin
                    if (c == tk_delim)
                    begin
                        if (tk_held_v && tk_held == CH_BSLASH)
                            tk_held = c;   // escaped quote replaces the backslash
                        else
                        begin
                            if (tk_held_v)
                                push_token_char(tk_held, 1'b1, K_STR, 1'b1);
                            else
                                push_token_char(8'h00, 1'b0, K_STR, 1'b1);
                            tk_held_v = 1'b0;
                            tk_held   = 8'h00;
                            tk_len    = 8'h00;
                            tk_mode   = M_IDLE;
                        end
                    end
                    else
                        token_append(c, K_STR);
                end
                default:
                begin
                    tk_mode = M_IDLE;
                    idle_byte(c);
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- driver

    // Hold the payload while stalled; after each transaction either present the next
    // byte or drop valid for a gap. Bursts and gaps are random, some gaps are zero.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                tokenize_byte(in_item);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    in_item  <= byte_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Check each accepted token transaction against the oldest expectation, and
    // drive out_stall from a randomly chosen pattern: none, random,
    // short periodic, and long stretches. Fields print as char/has/kind/last.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            cyc        <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (token_q.size() == 0)
                begin
                    $display("%0t: unexpected token %02h/%0d/%0d/%0d",
                             $time, out_item.out_char, out_item.has_char, out_item.kind,
                             out_item.last);
                    err_count <= err_count + 1;
                end
                else if (out_item.out_char !== token_q[0].out_char ||
                         out_item.has_char !== token_q[0].has_char ||
                         out_item.kind     !== token_q[0].kind ||
                         out_item.last     !== token_q[0].last)
                begin
                    $display("%0t: mismatch expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                             $time, token_q[0].out_char, token_q[0].has_char, token_q[0].kind,
                             token_q[0].last, out_item.out_char, out_item.has_char,
                             out_item.kind, out_item.last);
                    err_count <= err_count + 1;
                    void'(token_q.pop_front());
                end
                else
                    void'(token_q.pop_front());
            end
            cyc <= cyc + 1;
            if (cyc % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 35);
                2: out_stall <= (cyc % 7) < 3;
                default: out_stall <= (cyc % 40) < 15;
            endcase
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_byte(input logic [7:0] c);
        ctw_in_t it;
        it.ch           = c;
        it.end_of_input = 1'b0;
        byte_q.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // End of input with a random, ignored ch.
    task automatic add_end();
        ctw_in_t it;
        it.ch           = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        byte_q.push_back(it);
    endtask

    function automatic logic [7:0] rand_word_char();
        int unsigned r;
        r = $urandom_range(0, 63);
        if (r < 26)
            return 8'h61 + 8'(r);
        else if (r < 52)
            return 8'h41 + 8'(r - 26);
        else if (r < 62)
            return 8'h30 + 8'(r - 52);
        else
            return CH_UNDER;
    endfunction

    task automatic add_ident(input int unsigned n);
        logic [7:0] c;
        c = rand_word_char();
        if (c >= "0" && c <= "9")
            c = CH_UNDER;
        add_byte(c);
        for (int i = 1; i < n; i++)
            add_byte(rand_word_char());
    endtask

    // A literal with random content, some escaped delimiters, closed or not.
    task automatic add_literal(input int unsigned n);
        logic [7:0] d;
        logic [7:0] c;
        d = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        add_byte(d);
        for (int i = 0; i < n; i++)
        begin
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(32, 126));
            if ($urandom_range(0, 5) == 0)
            begin
                add_byte(CH_BSLASH);
                add_byte(d);
            end
            else if (c == d)
                add_byte("x");
            else
                add_byte(c);
        end
        if ($urandom_range(0, 9) != 0)
            add_byte(d);
    endtask

    task automatic add_block_comment(input int unsigned n);
        logic [7:0] pick [6];
        pick = '{CH_STAR, CH_NL, "a", CH_SLASH, 8'h20, CH_HASH};
        add_text("/*");
        for (int i = 0; i < n; i++)
            add_byte($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                                               : pick[$urandom_range(0, 5)]);
        add_text("*/");
    endtask

    // A line comment or a preprocessor line, with random printable content.
    task automatic add_line(input bit prep, input int unsigned n);
        if (prep)
        begin
            add_byte(CH_NL);
            if ($urandom_range(0, 1))
                add_byte(8'h20);
            add_byte(CH_HASH);
        end
        else
            add_text("//");
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(32, 126)));
        add_byte(CH_NL);
    endtask

    // Mostly well-formed C fragments with random content, some noise and cut-offs.
    task automatic add_random_source(input int unsigned target, input logic [7:0] lim);
        int unsigned start;
        int unsigned id_max;
        logic [7:0]  sp [4];
        sp = '{8'h20, 8'h09, CH_NL, 8'h0D};
        start  = byte_q.size();
        id_max = (lim <= 12) ? lim + 2 : 10;
        while (byte_q.size() - start < target)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: add_ident($urandom_range(1, id_max));
                4, 5:       add_literal($urandom_range(0, 6));
                6:          add_line(1'b0, $urandom_range(0, 5));
                7:          add_block_comment($urandom_range(0, 6));
                8:          add_line(1'b1, $urandom_range(0, 4));
                9, 10:      add_byte(sp[$urandom_range(0, 3)]);
                11, 12:     add_byte(8'("!" + $urandom_range(0, 14)));
                13:
                begin
                    add_byte(CH_SLASH);
                    add_byte(8'($urandom_range(32, 126)));
                end
                14, 15, 16: add_byte(8'($urandom_range(0, 255)));
                17:         add_byte(CH_HASH);
                18:         add_end();
                default:    add_byte(sp[$urandom_range(0, 3)]);
            endcase
        end
        add_end();
    endtask

    // Wait until every byte is taken and every token character has come out, then
    // let the pipeline settle so that a trailing whitespace byte is fully consumed.
    task automatic wait_drained();
        int unsigned w;
        w = 0;
        while ((byte_q.size() != 0 || in_valid || token_q.size() != 0) && w < 40000)
        begin
            @(negedge clk);
            w++;
        end
        repeat (8) @(negedge clk);
    endtask

    // Write max_token_len through the cfg channel while the block is idle.
    task automatic write_max_len(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tk_max = v;
    endtask

    initial
    begin
        logic [7:0] lim_list [5];
        tk_max = MAX_TOKEN_LEN_RESET;
        clear_tokenizer();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: preprocessor line after a blank, lone slash, block comment across
        // a newline, hash at a line start after the comment, escaped quote, empty
        // character literal, high and control bytes, hash mid-line, then end of input
        // with an open identifier, an empty open literal and a pending slash.
        add_text(" #d\nab/c/*\n*/#\n\"x\\\"\"'' ");
        add_byte(8'hFF);
        add_byte(8'h01);
        add_text("#ab");
        add_end();
        add_byte(CH_DQUOTE);
        add_end();
        add_byte(CH_SLASH);
        add_end();
        wait_drained();

        lim_list = '{8'd1, 8'd255, 8'd4, 8'($urandom_range(2, 12)), MAX_TOKEN_LEN_RESET};
        foreach (lim_list[p])
        begin
            write_max_len(lim_list[p]);
            add_random_source(40, lim_list[p]);
            // Hold the sender until the block has drained before the next setting.
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (token_q.size() != 0)
            $display("%0t: %0d expected token characters never arrived", $time, token_q.size());
        if (err_count == 0 && token_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ctw_pkg.sv
rtl/ctw_step.sv
rtl/ctw_outbuf.sv
rtl/c_source_word_tokenizer.sv
tb/c_source_word_tokenizer_tb.sv
